// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define CDA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calendar date advance assertion failed");

// Property checked on every rising clock edge, reset included.
`define CDA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("calendar date advance reset assertion failed");

`endif

// ----- rtl/cda_pkg.sv -----
package cda_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_SET     = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_COMPARE = 2'd2;

  // Date after reset and calendar constants.
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [15:0] RESET_YEAR  = 16'd1900;
  localparam logic [3:0]  JANUARY     = 4'd1;
  localparam logic [3:0]  DECEMBER    = 4'd12;
  localparam logic [4:0]  LEAP_FEB    = 5'd29;

  // Year / 100 is estimated as (year * 655) >> 16, which is low by at most one.
  localparam logic [9:0]  RECIP_100   = 10'd655;
  localparam logic [16:0] CENTURY     = 17'd100;

  // Command transaction.
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [15:0] in_year;
    logic [15:0] add_days;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [15:0] out_year;
    logic        rejected;
    logic        is_earlier;
    logic        year_wrapped;
  } rsp_t;

  // Length of a month; zero for a month code outside 1 to 12.
  function automatic logic [4:0] days_of(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? LEAP_FEB : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/cda_cmd_if.sv -----
interface cda_cmd_if;
  import cda_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/cda_rsp_if.sv -----
interface cda_rsp_if;
  import cda_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/calendar_date_advance.sv -----
// Calendar date register. It holds one Gregorian date, 1900-01-01 after reset, and
// answers every command transaction with exactly one result transaction carrying the
// stored date. The command port is ready only while no command is being worked on;
// a finished result sits in an output register, so a new command may be taken while
// the previous result still waits. A set passes through S_MUL, S_MOD and S_CHECK, a
// compare through S_CMP, and an unused code goes straight to S_FINISH. An advance
// passes through S_MUL and S_MOD, then loops in S_STEP over each month boundary
// crossed, going back through S_MUL and S_MOD at each year boundary. A result that
// finishes while the previous one is still held by a stalled receiver waits for that
// stall to end. The month-rollover loop moves one month per cycle through a single
// shared subtractor, except at a year boundary, where it waits on the registered
// leap-year unit, which is consulted once per new year.
module calendar_date_advance (
  input logic     clk,
  input logic     rst,
  cda_cmd_if.sink   cmd,
  cda_rsp_if.source rsp
);
  import cda_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_MOD    = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_STEP   = 7'b0010000,
    S_CMP    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t      state;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [15:0] cur_year;
  logic [1:0]  func;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [15:0] in_year;
  logic [16:0] day_acc;
  logic        rejected;
  logic        is_earlier;
  logic        year_wrapped;
  logic        rsp_valid;
  rsp_t        rsp_data;

  logic [15:0] leap_year;
  logic        leap;
  logic [3:0]  len_month;
  logic [4:0]  len;
  logic [24:0] alu_a;
  logic [24:0] alu_b;
  logic [24:0] alu_diff;
  logic        alu_borrow;
  logic        alu_gt;
  logic        rsp_load;

  // Leap-year unit works on the year under test.
  assign leap_year = (func == FUNC_SET) ? in_year : cur_year;

  cda_leap u_leap (
    .clk  (clk),
    .year (leap_year),
    .leap (leap)
  );

  // Month length for the month being checked or stepped.
  assign len_month = state[3] ? in_month : cur_month;
  assign len       = days_of(len_month, leap);

  // Shared subtractor: day against month length, or whole date against given date.
  always_comb begin
    unique case (state)
      S_CMP: begin
        alu_a = {cur_year, cur_month, cur_day};
        alu_b = {in_year, in_month, in_day};
      end
      S_CHECK: begin
        alu_a = {20'd0, in_day};
        alu_b = {20'd0, len};
      end
      S_STEP: begin
        alu_a = {8'd0, day_acc};
        alu_b = {20'd0, len};
      end
      default: begin
        alu_a = 25'd0;
        alu_b = 25'd0;
      end
    endcase
    {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
    alu_gt = !alu_borrow && (alu_diff != 25'd0);
  end

  // The output register takes the result when it is empty or being drained.
  assign rsp_load = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  // Sequencer and date state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_month <= RESET_MONTH;
      cur_day   <= RESET_DAY;
      cur_year  <= RESET_YEAR;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            func         <= cmd.data.func;
            in_month     <= cmd.data.in_month;
            in_day       <= cmd.data.in_day;
            in_year      <= cmd.data.in_year;
            day_acc      <= {12'd0, cur_day} + {1'b0, cmd.data.add_days};
            rejected     <= 1'b0;
            is_earlier   <= 1'b0;
            year_wrapped <= 1'b0;
            case (cmd.data.func) inside
              FUNC_SET, FUNC_ADVANCE: state <= S_MUL;
              FUNC_COMPARE:           state <= S_CMP;
              default:                state <= S_FINISH;
            endcase
          end
        end
        S_MUL: begin
          state <= S_MOD;
        end
        S_MOD: begin
          state <= (func == FUNC_SET) ? S_CHECK : S_STEP;
        end
        S_CHECK: begin
          if ((in_day == 5'd0) || (in_month < JANUARY) || (in_month > DECEMBER) || alu_gt) begin
            rejected <= 1'b1;
          end else begin
            cur_month <= in_month;
            cur_day   <= in_day;
            cur_year  <= in_year;
          end
          state <= S_FINISH;
        end
        S_STEP: begin
          // Consume one whole month while the day count runs past its end.
          if (alu_gt) begin
            day_acc <= alu_diff[16:0];
            if (cur_month == DECEMBER) begin
              cur_month <= JANUARY;
              if (cur_year == 16'hFFFF) begin
                cur_year     <= 16'd0;
                year_wrapped <= 1'b1;
              end else begin
                cur_year <= cur_year + 16'd1;
              end
              state <= S_MUL;
            end else begin
              cur_month <= cur_month + 4'd1;
            end
          end else begin
            cur_day <= day_acc[4:0];
            state   <= S_FINISH;
          end
        end
        S_CMP: begin
          is_earlier <= alu_borrow;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= '{out_month:    cur_month,
                    out_day:      cur_day,
                    out_year:     cur_year,
                    rejected:     rejected,
                    is_earlier:   is_earlier,
                    year_wrapped: year_wrapped};
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

// ----- rtl/cda_leap.sv -----
module cda_leap (
  input  logic        clk,
  input  logic [15:0] year,
  output logic        leap
);
  import cda_pkg::*;

  logic [25:0] prod;
  logic [15:0] year_q;
  logic [9:0]  q_est;
  logic [16:0] hund;
  logic [16:0] rem_est;
  logic        rem_over;
  logic [16:0] rem;
  logic [9:0]  quot;
  logic        leap_next;

  // First stage: reciprocal multiply for the century count.
  always_ff @(posedge clk) begin
    prod   <= {10'd0, year} * {16'd0, RECIP_100};
    year_q <= year;
  end

  // Second stage: remainder by 100 with one correction step, then the 4/100/400 rule.
  always_comb begin
    q_est     = prod[25:16];
    hund      = {1'b0, q_est, 6'd0} + {2'b0, q_est, 5'd0} + {5'b0, q_est, 2'd0};
    rem_est   = {1'b0, year_q} - hund;
    rem_over  = (rem_est >= CENTURY);
    rem       = rem_over ? (rem_est - CENTURY) : rem_est;
    quot      = q_est + {9'd0, rem_over};
    leap_next = (year_q[1:0] == 2'd0) && ((rem != 17'd0) || (quot[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    leap <= leap_next;
  end

endmodule

// ----- rtl/cda_checker.sv -----
`include "assert_macros.svh"

module cda_assertions (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cda_pkg::rsp_t rsp_data
);
  import cda_pkg::*;

  // A stalled result transaction stays offered and unchanged.
  `CDA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
  `CDA_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data))

  // Every accepted command keeps the block busy for at least the next cycle.
  `CDA_ASSERT(a_busy_after_accept, cmd_valid && cmd_ready |=> !cmd_ready)

  // Each result raises at most one of its flags.
  `CDA_ASSERT(a_flags_exclusive,
    rsp_valid |-> $onehot0({rsp_data.rejected, rsp_data.is_earlier, rsp_data.year_wrapped}))

  // Reset leaves the block ready with no result pending.
  `CDA_ASSERT_ALWAYS(a_reset_idle, rst |=> cmd_ready && !rsp_valid)

endmodule

bind calendar_date_advance cda_assertions u_cda_assertions (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
